@@ rtl/dynamic_priority_scheduler_top_defines.svh @@
// Assertion macros for the dynamic priority scheduler
`ifndef DYNAMIC_PRIORITY_SCHEDULER_TOP_DEFINES_SVH
`define DYNAMIC_PRIORITY_SCHEDULER_TOP_DEFINES_SVH

// Check a property on every clock outside reset
`define DPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle
`define DPS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/dps_pkg.sv @@
// Types, codes and helpers shared by the scheduler modules
`timescale 1ns / 1ps
package dps_pkg;

  localparam logic [1:0] ST_READY   = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_BLOCKED = 2'd2;
  localparam logic [1:0] ST_ENDED   = 2'd3;

  localparam logic [2:0] EV_LOADED  = 3'd0;
  localparam logic [2:0] EV_RAN     = 3'd1;
  localparam logic [2:0] EV_ENDED   = 3'd2;
  localparam logic [2:0] EV_BLOCKED = 3'd3;
  localparam logic [2:0] EV_IDLE    = 3'd4;

  localparam logic FN_LOAD = 1'b0;
  localparam logic FN_TICK = 1'b1;

  localparam logic OP_GRANT = 1'b0;
  localparam logic OP_AGE   = 1'b1;

  localparam logic [1:0] ADDR_PROCESS_COUNT = 2'd0;

  localparam logic signed [16:0] PRIO_DROP = 17'sd3;
  localparam logic signed [16:0] PRIO_GAIN = 17'sd1;

  typedef struct packed {
    logic signed [15:0] prio;
    logic [15:0]        remaining;
    logic [15:0]        used;
    logic [15:0]        countdown;
    logic [15:0]        blen;
  } proc_t;

  typedef struct packed {
    logic op;
    logic skip_age;
  } alu_ctl_t;

  typedef struct packed {
    logic       ended;
    logic [2:0] event_code;
  } alu_res_t;

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v[16] == v[15]) begin
      r = v[15:0];
    end else if (v[16]) begin
      r = 16'sh8000;
    end else begin
      r = 16'sh7fff;
    end
    return r;
  endfunction

endpackage

@@ rtl/dps_alu.sv @@
// Shared slot update unit: grant update and aging/countdown of one slot
`timescale 1ns / 1ps
module dps_alu (
  input  dps_pkg::alu_ctl_t ctl,
  input  dps_pkg::proc_t    ent_in,
  input  logic [1:0]        st_in,
  output dps_pkg::proc_t    ent_out,
  output logic [1:0]        st_out,
  output dps_pkg::alu_res_t res
);
  import dps_pkg::*;

  logic [15:0]        rem_dec;
  logic [15:0]        cd_dec;
  logic [15:0]        bl_dec;
  logic signed [16:0] prio_ext;
  logic signed [16:0] prio_dn;
  logic signed [16:0] prio_up;
  logic [1:0]         st_mid;

  assign rem_dec  = (ent_in.remaining != 16'd0) ? ent_in.remaining - 16'd1 : 16'd0;
  assign cd_dec   = ent_in.countdown - 16'd1;
  assign bl_dec   = (ent_in.blen != 16'd0) ? ent_in.blen - 16'd1 : 16'd0;
  assign prio_ext = {ent_in.prio[15], ent_in.prio};
  assign prio_dn  = prio_ext - PRIO_DROP;
  assign prio_up  = prio_ext + PRIO_GAIN;

  always_comb begin
    ent_out = ent_in;
    st_out  = st_in;
    st_mid  = st_in;
    res     = '0;
    if (ctl.op == OP_GRANT) begin
      ent_out.used      = (ent_in.used == 16'hffff) ? ent_in.used : ent_in.used + 16'd1;
      ent_out.remaining = rem_dec;
      if (rem_dec == 16'd0) begin
        ent_out.prio   = '0;
        st_out         = ST_ENDED;
        res.ended      = 1'b1;
        res.event_code = EV_ENDED;
      end else begin
        ent_out.prio   = sat16(prio_dn);
        st_out         = ST_RUNNING;
        res.event_code = EV_RAN;
        if (ent_in.countdown != 16'd0 && ent_in.blen != 16'd0) begin
          ent_out.countdown = cd_dec;
          if (cd_dec == 16'd0) begin
            st_out         = ST_BLOCKED;
            res.event_code = EV_BLOCKED;
          end
        end
      end
    end else begin
      if (!ctl.skip_age && (st_in == ST_READY || st_in == ST_RUNNING)) begin
        ent_out.prio = sat16(prio_up);
        st_mid       = ST_READY;
      end
      st_out = st_mid;
      if (st_mid == ST_BLOCKED) begin
        ent_out.blen = bl_dec;
        if (bl_dec == 16'd0) begin
          st_out = ST_READY;
        end
      end
    end
  end

endmodule

@@ rtl/dynamic_priority_scheduler_top.sv @@
// Top level of the dynamic priority scheduler with aging
//
//   channel   handshake                        payload
//   command   start / busy                     func slot start_priority total_slices
//                                              block_after block_length
//   result    done (one-cycle strobe)          event_res granted_slot granted_priority
//                                              ended_count all_done
//   config    psel penable pwrite pready       paddr pwdata prdata
//
// With n slots in use, a tick scans the n slots, makes one grant update and then
// ages the n slots; an idle tick makes no grant update and a load checks the n
// slots; with no slot in use a command finishes on accept. The slot table is
// walked one entry a cycle; each slot update uses the single shared update unit.
// Reset marks every slot ended. The result beat is not stalled by the receiver.
`timescale 1ns / 1ps
`include "dynamic_priority_scheduler_top_defines.svh"
module dynamic_priority_scheduler_top #(
  parameter int PROCESSES = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               func,
  input  logic [2:0]         slot,
  input  logic signed [15:0] start_priority,
  input  logic [15:0]        total_slices,
  input  logic [15:0]        block_after,
  input  logic [15:0]        block_length,
  output logic               done,
  output logic [2:0]         event_res,
  output logic [2:0]         granted_slot,
  output logic signed [15:0] granted_priority,
  output logic [3:0]         ended_count,
  output logic               all_done,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import dps_pkg::*;

  localparam int IDX_W = $clog2(PROCESSES);
  localparam int CNT_W = $clog2(PROCESSES + 1);
  localparam int CMP_W = CNT_W + 4;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_GRANT = 3'd2;
  localparam logic [2:0] S_AGE   = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;

  logic [2:0]         state;
  logic [3:0]         process_count;
  logic [3:0]         ended_counter;
  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   n_use;
  logic [CMP_W-1:0]   pc_w;
  logic [CMP_W-1:0]   lim;
  logic [IDX_W-1:0]   idx_a;
  logic [IDX_W-1:0]   gidx;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  logic               found;
  logic               live;
  logic               live_next;
  logic [2:0]         ev;
  logic signed [15:0] best_prio;
  logic signed [15:0] gprio;
  logic               last;
  logic               elig;
  logic               take;
  logic               slot_ok;
  logic               accept;
  logic               fin;
  logic               fin_grant;
  logic [2:0]         fin_ev;
  logic               wr_en;
  proc_t              wr_ent;
  logic [1:0]         wr_st;
  proc_t              rd_ent;
  logic [1:0]         rd_st;
  proc_t              alu_ent;
  logic [1:0]         alu_st;
  alu_ctl_t           alu_ctl;
  alu_res_t           alu_res;
  logic               cfg_wr;

  proc_t              mem [PROCESSES];
  logic [1:0]         st_mem [PROCESSES];

  assign pready = 1'b1;
  assign prdata = 32'(process_count);
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_PROCESS_COUNT);

  assign pc_w    = CMP_W'(process_count);
  assign lim     = CMP_W'(PROCESSES);
  assign n_use   = (pc_w > lim) ? lim[CNT_W-1:0] : pc_w[CNT_W-1:0];
  assign slot_ok = CMP_W'(slot) < lim;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign idx_a  = idx[IDX_W-1:0];
  assign last   = (CNT_W'(idx + 1'b1) == n_use);

  assign rd_addr = (state == S_GRANT) ? gidx : idx_a;
  assign rd_ent  = mem[rd_addr];
  assign rd_st   = st_mem[rd_addr];

  assign elig = (rd_st == ST_READY) || (rd_st == ST_RUNNING);
  assign take = (state == S_SCAN) && elig && (!found || $signed(rd_ent.prio) > best_prio);

  assign alu_ctl.op       = (state == S_GRANT) ? OP_GRANT : OP_AGE;
  assign alu_ctl.skip_age = found && (idx_a == gidx);

  dps_alu u_alu (
    .ctl     (alu_ctl),
    .ent_in  (rd_ent),
    .st_in   (rd_st),
    .ent_out (alu_ent),
    .st_out  (alu_st),
    .res     (alu_res)
  );

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_addr;
    wr_ent  = alu_ent;
    wr_st   = alu_st;
    if (accept && func == FN_LOAD && slot_ok) begin
      wr_en            = 1'b1;
      wr_addr          = IDX_W'(slot);
      wr_ent.prio      = start_priority;
      wr_ent.remaining = total_slices;
      wr_ent.used      = '0;
      wr_ent.countdown = block_after;
      wr_ent.blen      = block_length;
      wr_st            = ST_READY;
    end else if (state == S_GRANT || state == S_AGE) begin
      wr_en = 1'b1;
    end
  end

  always_comb begin
    live_next = live;
    if (state == S_AGE) begin
      live_next = live || (alu_st != ST_ENDED);
    end else if (state == S_CHECK) begin
      live_next = live || (rd_st != ST_ENDED);
    end
  end

  assign fin = (accept && n_use == '0) || ((state == S_AGE || state == S_CHECK) && last);
  assign fin_grant = (state != S_IDLE) && found;
  assign fin_ev = (state != S_IDLE) ? ev : ((func == FN_TICK) ? EV_IDLE : EV_LOADED);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PROCESSES; i++) begin
        st_mem[i] <= ST_ENDED;
      end
    end else if (wr_en) begin
      st_mem[wr_addr] <= wr_st;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      event_res        <= fin_ev;
      granted_slot     <= fin_grant ? 3'(gidx) : 3'd0;
      granted_priority <= fin_grant ? gprio : 16'sd0;
      ended_count      <= ended_counter;
      all_done         <= (state == S_IDLE) ? 1'b1 : !live_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done          <= 1'b0;
      found         <= 1'b0;
      process_count <= 4'd5;
      ended_counter <= 4'd0;
    end else begin
      done <= fin;
      if (cfg_wr) begin
        process_count <= pwdata[3:0];
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            found <= 1'b0;
            idx   <= '0;
            live  <= 1'b0;
            ev    <= (func == FN_TICK) ? EV_IDLE : EV_LOADED;
            if (n_use != '0) begin
              state <= (func == FN_TICK) ? S_SCAN : S_CHECK;
            end
          end
        end
        S_SCAN: begin
          if (take) begin
            found     <= 1'b1;
            gidx      <= idx_a;
            best_prio <= $signed(rd_ent.prio);
          end
          if (last) begin
            idx   <= '0;
            state <= (found || take) ? S_GRANT : S_AGE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_GRANT: begin
          gprio <= $signed(alu_ent.prio);
          ev    <= alu_res.event_code;
          if (alu_res.ended && ended_counter != 4'hf) begin
            ended_counter <= ended_counter + 4'd1;
          end
          state <= S_AGE;
        end
        S_AGE, S_CHECK: begin
          live <= live_next;
          if (last) begin
            state <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `DPS_ASSERT_IMPL(a_done_idle, done, !busy, "result beat while still busy")
  `DPS_ASSERT_IMPL(a_grant_elig, state == S_GRANT, st_mem[gidx] == ST_READY || st_mem[gidx] == ST_RUNNING, "granted slot not eligible")
  `DPS_ASSERT_IMPL(a_gidx_range, found && state != S_IDLE, CNT_W'(gidx) < n_use, "granted slot outside slots in use")
  `DPS_ASSERT(a_ended_mono, $past(rst) || ended_counter >= $past(ended_counter), "ended count went down")

endmodule
